[hw/rtl/fcdma_pkg.sv]
package fcdma_pkg;

  localparam int CH_NUM = 4;
  localparam int CH_W   = 2;

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TIMER = 2'd2,
    OP_IDLE  = 2'd3
  } op_t;

  // low byte of a port that addresses this block
  localparam logic [7:0] PORT_SEL = 8'h77;

  // register selects (high byte of port)
  localparam logic [7:0] REG_COMMAND  = 8'h8c;
  localparam logic [7:0] REG_REQUEST  = 8'h9c;
  localparam logic [7:0] REG_MASK_ONE = 8'hac;
  localparam logic [7:0] REG_MODE     = 8'hbc;
  localparam logic [7:0] REG_CLR_FF   = 8'hcc;
  localparam logic [7:0] REG_MCLEAR   = 8'hdc;
  localparam logic [7:0] REG_CLR_MASK = 8'hec;
  localparam logic [7:0] REG_MASK_ALL = 8'hfc;

  // mode byte is stored shifted right by two; the flags are tested on the
  // stored value, so they sit two bits below their mode byte positions
  localparam int MODE_AUTOINIT  = 2;
  localparam int MODE_DECREMENT = 3;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  localparam int CMD_DISABLE = 2;

  localparam logic [3:0] MASK_ALL = 4'hf;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

endpackage

[hw/rtl/four_channel_dma_controller.sv]
// channel | direction | tdata (low bit up)                                    | tuser
// in_     | slave     | port[15:0] write_data[23:16] expired_mask[27:24]      | operation[1:0]
// out_    | master    | read_data[7:0] fetch_channel[9:8] fetch_bank[17:10]   | read_hit[0]
//         |           | fetch_address[33:18]                                  | fetch_valid[1]
//
// one transfer in, one transfer out; each item is decoded and applied to the
// channel registers in the cycle it is taken, the result is registered in the
// output register, so one item per cycle is sustained while the output is not stalled.
// synchronous active-low reset puts all channels masked, the rest of the control state zero.
// a stalled output holds in_tready low only while its register is full.
module four_channel_dma_controller
  import fcdma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // port, write_data, expired_mask, zero pad
  input  logic [IN_USER_W-1:0]  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // read_data, fetch_channel, fetch_bank,
                                            // fetch_address, zero pad
  output logic [OUT_USER_W-1:0] out_tuser   // read_hit, fetch_valid
);

  // channel register file
  logic [7:0]  bank_r     [CH_NUM];
  logic [15:0] base_addr_r[CH_NUM];
  logic [15:0] cur_addr_r [CH_NUM];
  logic [15:0] base_cnt_r [CH_NUM];
  logic [15:0] cur_cnt_r  [CH_NUM];
  logic [5:0]  mode_r     [CH_NUM];
  logic [7:0]  bank_nxt     [CH_NUM];
  logic [15:0] base_addr_nxt[CH_NUM];
  logic [15:0] cur_addr_nxt [CH_NUM];
  logic [15:0] base_cnt_nxt [CH_NUM];
  logic [15:0] cur_cnt_nxt  [CH_NUM];
  logic [5:0]  mode_nxt     [CH_NUM];

  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] stat_r, stat_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [3:0] req_r, req_nxt;
  logic       ff_r, ff_nxt;

  // output register
  logic        out_valid_r;
  logic        hit_r, hit_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  logic        fvalid_r, fvalid_nxt;
  logic [1:0]  fch_r, fch_nxt;
  logic [7:0]  fbank_r, fbank_nxt;
  logic [15:0] faddr_r, faddr_nxt;

  // input fields
  op_t        op;
  logic [15:0] port;
  logic [7:0]  wdata;
  logic [3:0]  expired;
  logic [7:0]  hi;
  logic        sel;
  logic        accept;

  assign op      = op_t'(in_tuser[1:0]);
  assign port    = in_tdata[15:0];
  assign wdata   = in_tdata[23:16];
  assign expired = in_tdata[27:24];
  assign hi      = port[15:8];
  assign sel     = (port[7:0] == PORT_SEL);

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // register decode
  logic is_bank, is_addr, is_cnt;
  assign is_bank = (hi[3:0] == 4'h7) && (hi[7:6] == 2'b00);
  assign is_addr = (hi[3:0] == 4'hc) && !hi[7] && !hi[4];
  assign is_cnt  = (hi[3:0] == 4'hc) && !hi[7] && hi[4];

  // serving channel search, lowest number wins
  logic [7:0]    stat_req;
  logic          found;
  logic [CH_W-1:0] sch;
  logic          svc_en;

  assign svc_en   = !cmd_r[CMD_DISABLE] && (mask_r != MASK_ALL);
  assign stat_req = stat_r | {expired, 4'b0000};

  always_comb begin
    found = 1'b0;
    sch   = '0;
    for (int k = 0; k < CH_NUM; k++) begin
      if (!found && !mask_r[k] && stat_req[4+k]) begin
        found = 1'b1;
        sch   = CH_W'(k);
      end
    end
  end

  // one channel index per item, shared by address/count accesses and service
  logic [CH_W-1:0] ich;
  logic [3:0]      ich_bit;
  logic [3:0]      wbit;
  logic [15:0]     a_cur, c_cur, a_base, c_base;
  logic [5:0]      m_cur;
  logic [15:0]     put_word;
  logic [15:0]     cnt_dec;
  logic [15:0]     addr_use;

  assign ich     = (op == OP_TIMER) ? sch : hi[6:5];
  assign ich_bit = 4'b0001 << ich;
  assign wbit    = 4'b0001 << wdata[1:0];
  assign a_cur   = cur_addr_r[ich];
  assign c_cur   = cur_cnt_r[ich];
  assign a_base  = base_addr_r[ich];
  assign c_base  = base_cnt_r[ich];
  assign m_cur   = mode_r[ich];
  assign cnt_dec = c_cur - 16'd1;

  // byte lane of a 16-bit base register picked by the flip-flop
  always_comb begin
    logic [15:0] old_word;
    old_word = is_cnt ? c_base : a_base;
    put_word = ff_r ? {wdata, old_word[7:0]} : {old_word[15:8], wdata};
  end

  // next state and result of the item being taken
  always_comb begin
    bank_nxt      = bank_r;
    base_addr_nxt = base_addr_r;
    cur_addr_nxt  = cur_addr_r;
    base_cnt_nxt  = base_cnt_r;
    cur_cnt_nxt   = cur_cnt_r;
    mode_nxt      = mode_r;
    cmd_nxt       = cmd_r;
    stat_nxt      = stat_r;
    mask_nxt      = mask_r;
    req_nxt       = req_r;
    ff_nxt        = ff_r;
    hit_nxt       = 1'b0;
    rdata_nxt     = '0;
    fvalid_nxt    = 1'b0;
    fch_nxt       = '0;
    fbank_nxt     = '0;
    faddr_nxt     = '0;
    addr_use      = a_cur;

    if (accept) begin
      unique case (op)
        OP_WRITE: begin
          if (sel) begin
            if (is_bank) begin
              bank_nxt[hi[5:4]] = wdata;
            end else if (is_addr) begin
              base_addr_nxt[ich] = put_word;
              cur_addr_nxt[ich]  = put_word;
              ff_nxt             = !ff_r;
            end else if (is_cnt) begin
              base_cnt_nxt[ich] = put_word;
              cur_cnt_nxt[ich]  = put_word;
              ff_nxt            = !ff_r;
            end else begin
              unique case (hi)
                REG_COMMAND:  cmd_nxt = wdata;
                REG_REQUEST:  req_nxt = wdata[2] ? (req_r | wbit) : (req_r & ~wbit);
                REG_MASK_ONE: mask_nxt = wdata[2] ? (mask_r | wbit) : (mask_r & ~wbit);
                REG_MODE:     mode_nxt[wdata[1:0]] = wdata[7:2];
                REG_CLR_FF:   ff_nxt = 1'b0;
                REG_MCLEAR: begin
                  for (int k = 0; k < CH_NUM; k++) begin
                    bank_nxt[k]      = '0;
                    base_addr_nxt[k] = '0;
                    cur_addr_nxt[k]  = '0;
                    base_cnt_nxt[k]  = '0;
                    cur_cnt_nxt[k]   = '0;
                    mode_nxt[k]      = '0;
                  end
                  cmd_nxt  = '0;
                  stat_nxt = '0;
                  mask_nxt = MASK_ALL;
                  req_nxt  = '0;
                  ff_nxt   = 1'b0;
                end
                REG_CLR_MASK: mask_nxt = '0;
                REG_MASK_ALL: mask_nxt = wdata[3:0];
                default: ;
              endcase
            end
          end
        end

        OP_READ: begin
          if (sel) begin
            if (is_addr || is_cnt) begin
              hit_nxt   = 1'b1;
              ff_nxt    = !ff_r;
              rdata_nxt = is_cnt ? (ff_r ? c_cur[15:8] : c_cur[7:0])
                                 : (ff_r ? a_cur[15:8] : a_cur[7:0]);
            end else if (hi == REG_COMMAND) begin
              hit_nxt   = 1'b1;
              rdata_nxt = stat_r;
              stat_nxt  = stat_r & 8'hf0;
            end else if (hi == REG_MCLEAR || hi == REG_MASK_ALL) begin
              // temporary register always reads zero
              hit_nxt = 1'b1;
            end
          end
        end

        OP_TIMER: begin
          if (svc_en) begin
            stat_nxt = stat_req;
            if (found) begin
              req_nxt  = req_r & ~ich_bit;
              stat_nxt = stat_req & ~{ich_bit, 4'b0000};
              cur_cnt_nxt[ich] = cnt_dec;
              fvalid_nxt = 1'b1;
              // terminal count: reload with autoinit, else self-mask
              if (cnt_dec == 16'd0) begin
                stat_nxt = stat_nxt | {4'b0000, ich_bit};
                if (m_cur[MODE_AUTOINIT]) begin
                  addr_use         = a_base;
                  cur_cnt_nxt[ich] = c_base;
                end else begin
                  mask_nxt   = mask_r | ich_bit;
                  fvalid_nxt = 1'b0;
                end
              end
              if (fvalid_nxt) begin
                fch_nxt   = ich;
                fbank_nxt = bank_r[ich];
                faddr_nxt = addr_use;
                cur_addr_nxt[ich] = m_cur[MODE_DECREMENT] ? (addr_use - 16'd1)
                                                          : (addr_use + 16'd1);
                // block mode keeps the request standing
                if (m_cur[5:4] == MODE_BLOCK) begin
                  req_nxt  = req_nxt | ich_bit;
                  stat_nxt = stat_nxt | {ich_bit, 4'b0000};
                end
              end
            end
          end
        end

        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CH_NUM; k++) begin
        bank_r[k]      <= '0;
        base_addr_r[k] <= '0;
        cur_addr_r[k]  <= '0;
        base_cnt_r[k]  <= '0;
        cur_cnt_r[k]   <= '0;
        mode_r[k]      <= '0;
      end
      cmd_r       <= '0;
      stat_r      <= '0;
      mask_r      <= MASK_ALL;
      req_r       <= '0;
      ff_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bank_r      <= bank_nxt;
      base_addr_r <= base_addr_nxt;
      cur_addr_r  <= cur_addr_nxt;
      base_cnt_r  <= base_cnt_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      mode_r      <= mode_nxt;
      cmd_r       <= cmd_nxt;
      stat_r      <= stat_nxt;
      mask_r      <= mask_nxt;
      req_r       <= req_nxt;
      ff_r        <= ff_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r    <= hit_nxt;
      rdata_r  <= rdata_nxt;
      fvalid_r <= fvalid_nxt;
      fch_r    <= fch_nxt;
      fbank_r  <= fbank_nxt;
      faddr_r  <= faddr_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, faddr_r, fbank_r, fch_r, rdata_r};
  assign out_tuser  = {fvalid_r, hit_r};

endmodule

[hw/rtl/fcdma_checker.sv]
module fcdma_checker
  import fcdma_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // every input transfer yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer produced no result");

  // an empty output register never blocks the input once out of reset
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // a read hit only answers a bus read
  a_hit_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != OP_READ) |=> !out_tuser[0])
    else $error("read hit on a non-read item");

  // a fetch only follows a timer event
  a_fetch_from_timer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != OP_TIMER) |=> !out_tuser[1])
    else $error("fetch on a non-timer item");

endmodule

bind four_channel_dma_controller fcdma_checker u_fcdma_checker (.*);

[sim/four_channel_dma_controller_checker.sv]
`timescale 1ns / 1ps

module four_channel_dma_controller_checker
  import fcdma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // port, write_data, expired_mask, zero pad
  input  logic [IN_USER_W-1:0]  in_tuser,   // operation
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // read_data, fetch_channel, fetch_bank,
                                            // fetch_address, zero pad
  input  logic [OUT_USER_W-1:0] out_tuser,  // read_hit, fetch_valid
  output int                    fail_count,
  output int                    pending
);

  // low nibble of the per-channel address/count selects and of the bank selects
  localparam logic [3:0] CHAN_REG_NIB = 4'hc;
  localparam logic [3:0] BANK_REG_NIB = 4'h7;

  // bit positions inside the stored mode (mode byte shifted right by two)
  localparam int AUTOINIT_BIT  = 2;
  localparam int DECREMENT_BIT = 3;

  typedef struct packed {
    logic        read_hit;
    logic [7:0]  read_data;
    logic        fetch_valid;
    logic [1:0]  fetch_channel;
    logic [7:0]  fetch_bank;
    logic [15:0] fetch_address;
  } dma_result_t;

  // controller state as the block should hold it
  logic [7:0]  bank_q   [CH_NUM];
  logic [15:0] base_addr[CH_NUM];
  logic [15:0] cur_addr [CH_NUM];
  logic [15:0] base_cnt [CH_NUM];
  logic [15:0] cur_cnt  [CH_NUM];
  logic [5:0]  mode_q   [CH_NUM];
  logic [7:0]  cmd_q;
  logic [7:0]  stat_q;
  logic [3:0]  mask_q;
  logic [3:0]  req_q;
  logic        flip_q;

  dma_result_t expected_q[$];
  dma_result_t got;
  dma_result_t want;
  int          errors = 0;

  assign fail_count = errors;
  assign pending    = expected_q.size();

  function automatic void clear_model();
    for (int i = 0; i < CH_NUM; i++) begin
      bank_q[i]    = '0;
      base_addr[i] = '0;
      cur_addr[i]  = '0;
      base_cnt[i]  = '0;
      cur_cnt[i]   = '0;
      mode_q[i]    = '0;
    end
    cmd_q  = '0;
    stat_q = '0;
    mask_q = MASK_ALL;
    req_q  = '0;
    flip_q = 1'b0;
  endfunction

  // one byte of a 16-bit register through the byte flip-flop, low byte first
  function automatic logic [15:0] put_byte(logic [15:0] cur, logic [7:0] data);
    logic [15:0] r;
    r = flip_q ? {data, cur[7:0]} : {cur[15:8], data};
    flip_q = ~flip_q;
    return r;
  endfunction

  function automatic logic [7:0] get_byte(logic [15:0] cur);
    flip_q = ~flip_q;
    return flip_q ? cur[7:0] : cur[15:8];
  endfunction

  function automatic void bus_write(logic [7:0] hi, logic [7:0] data);
    logic [1:0] ch;
    logic [3:0] bit_sel;
    ch      = hi[6:5];
    bit_sel = 4'b0001 << data[1:0];
    if (hi[7:6] == 2'b00 && hi[3:0] == BANK_REG_NIB) begin
      bank_q[hi[5:4]] = data;
    end else if (!hi[7] && hi[3:0] == CHAN_REG_NIB) begin
      // address or count, base and current written together
      if (hi[4]) begin
        base_cnt[ch] = put_byte(base_cnt[ch], data);
        cur_cnt[ch]  = base_cnt[ch];
      end else begin
        base_addr[ch] = put_byte(base_addr[ch], data);
        cur_addr[ch]  = base_addr[ch];
      end
    end else begin
      case (hi)
        REG_COMMAND:  cmd_q = data;
        REG_REQUEST:  req_q = data[2] ? (req_q | bit_sel) : (req_q & ~bit_sel);
        REG_MASK_ONE: mask_q = data[2] ? (mask_q | bit_sel) : (mask_q & ~bit_sel);
        REG_MODE:     mode_q[data[1:0]] = data[7:2];
        REG_CLR_FF:   flip_q = 1'b0;
        REG_MCLEAR:   clear_model();
        REG_CLR_MASK: mask_q = '0;
        REG_MASK_ALL: mask_q = data[3:0];
        default: ;
      endcase
    end
  endfunction

  function automatic void bus_read(logic [7:0] hi, output logic hit, output logic [7:0] rd);
    logic [1:0] ch;
    ch  = hi[6:5];
    hit = 1'b1;
    rd  = '0;
    if (!hi[7] && hi[3:0] == CHAN_REG_NIB) begin
      rd = hi[4] ? get_byte(cur_cnt[ch]) : get_byte(cur_addr[ch]);
    end else if (hi == REG_COMMAND) begin
      // status read drops the finish bits
      rd     = stat_q;
      stat_q = stat_q & 8'hf0;
    end else if (hi != REG_MCLEAR && hi != REG_MASK_ALL) begin
      hit = 1'b0;
    end
  endfunction

  // one service of a channel: count down, terminal count, address step
  function automatic void serve_channel(logic [1:0] ch, output logic fetched,
                                        output logic [15:0] addr);
    logic [5:0] mode;
    mode    = mode_q[ch];
    fetched = 1'b0;
    addr    = '0;
    req_q[ch]      = 1'b0;
    stat_q[4 + ch] = 1'b0;
    cur_cnt[ch]    = cur_cnt[ch] - 16'd1;
    if (cur_cnt[ch] == 16'd0) begin
      stat_q[ch] = 1'b1;
      if (mode[AUTOINIT_BIT]) begin
        cur_addr[ch] = base_addr[ch];
        cur_cnt[ch]  = base_cnt[ch];
      end else begin
        mask_q[ch] = 1'b1;
        return;
      end
    end
    addr         = cur_addr[ch];
    cur_addr[ch] = mode[DECREMENT_BIT] ? cur_addr[ch] - 16'd1 : cur_addr[ch] + 16'd1;
    // block mode keeps the request alive
    if (mode[5:4] == MODE_BLOCK) begin
      req_q[ch]      = 1'b1;
      stat_q[4 + ch] = 1'b1;
    end
    fetched = 1'b1;
  endfunction

  function automatic dma_result_t predict_transfer(op_t op, logic [15:0] port,
                                                   logic [7:0] data, logic [3:0] expired);
    dma_result_t r;
    logic        sel;
    logic        found;
    logic        hit;
    logic [7:0]  rd;
    logic        fetched;
    logic [15:0] addr;
    r     = '0;
    sel   = (port[7:0] == PORT_SEL);
    found = 1'b0;
    case (op)
      OP_WRITE: if (sel) bus_write(port[15:8], data);
      OP_READ: begin
        if (sel) begin
          bus_read(port[15:8], hit, rd);
          r.read_hit  = hit;
          r.read_data = hit ? rd : 8'h00;
        end
      end
      OP_TIMER: begin
        if (!cmd_q[CMD_DISABLE] && mask_q != MASK_ALL) begin
          stat_q[7:4] = stat_q[7:4] | expired;
          // lowest numbered unmasked requester wins
          for (int k = 0; k < CH_NUM; k++) begin
            if (!found && !mask_q[k] && stat_q[4 + k]) begin
              found = 1'b1;
              serve_channel(k[1:0], fetched, addr);
              if (fetched) begin
                r.fetch_valid   = 1'b1;
                r.fetch_channel = k[1:0];
                r.fetch_bank    = bank_q[k];
                r.fetch_address = addr;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  initial clear_model();

  // predict on every input transfer, compare on every output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_transfer(op_t'(in_tuser), in_tdata[15:0],
                                              in_tdata[23:16], in_tdata[27:24]));
      end
      if (out_tvalid && out_tready) begin
        got.read_hit      = out_tuser[0];
        got.fetch_valid   = out_tuser[1];
        got.read_data     = out_tdata[7:0];
        got.fetch_channel = out_tdata[9:8];
        got.fetch_bank    = out_tdata[17:10];
        got.fetch_address = out_tdata[33:18];
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %0h",
                   $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("read_hit", 16'(want.read_hit), 16'(got.read_hit));
          check_field("read_data", 16'(want.read_data), 16'(got.read_data));
          check_field("fetch_valid", 16'(want.fetch_valid), 16'(got.fetch_valid));
          check_field("fetch_channel", 16'(want.fetch_channel), 16'(got.fetch_channel));
          check_field("fetch_bank", 16'(want.fetch_bank), 16'(got.fetch_bank));
          check_field("fetch_address", want.fetch_address, got.fetch_address);
        end
      end
    end
  end

endmodule

[sim/four_channel_dma_controller_tb.sv]
`timescale 1ns / 1ps

module four_channel_dma_controller_tb;
  import fcdma_pkg::*;

  // channel 0 selects; other channels are or-ed in
  localparam logic [7:0] REG_ADDR0  = 8'h0c;
  localparam logic [7:0] REG_COUNT0 = 8'h1c;
  localparam logic [7:0] REG_BANK0  = 8'h07;

  localparam int RANDOM_ITEMS = 1750;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  int   fail_count;
  int   pending;
  int   sent_count  = 0;
  bit   quiet_send  = 1'b0;
  bit   quiet_recv  = 1'b0;
  logic hold_off    = 1'b0;

  four_channel_dma_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  four_channel_dma_controller_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] addr_sel(logic [1:0] ch);
    return REG_ADDR0 | {1'b0, ch, 5'b00000};
  endfunction

  function automatic logic [7:0] count_sel(logic [1:0] ch);
    return REG_COUNT0 | {1'b0, ch, 5'b00000};
  endfunction

  function automatic logic [7:0] bank_sel(logic [1:0] ch);
    return REG_BANK0 | {2'b00, ch, 4'b0000};
  endfunction

  // one input transfer, then a random idle gap
  task automatic send_item(op_t op, logic [15:0] port, logic [7:0] data, logic [3:0] expired);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, expired, data, port};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    if ($urandom_range(0, 79) == 0) quiet_send = ~quiet_send;
    gap = quiet_send ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unused fields carry random values
  task automatic write_reg(logic [7:0] hi, logic [7:0] data);
    send_item(OP_WRITE, {hi, PORT_SEL}, data, 4'($urandom));
  endtask

  task automatic read_reg(logic [7:0] hi);
    send_item(OP_READ, {hi, PORT_SEL}, 8'($urandom), 4'($urandom));
  endtask

  task automatic timer_event(logic [3:0] expired);
    send_item(OP_TIMER, 16'($urandom), 8'($urandom), expired);
  endtask

  // address, count, mode, bank, unmask; sometimes without clearing the flip-flop
  task automatic program_channel(logic [1:0] ch);
    logic [15:0] cnt;
    logic [7:0]  mode_byte;
    logic [7:0]  rnd;
    cnt       = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    rnd       = 8'($urandom);
    mode_byte = {rnd[7:2], ch};
    if ($urandom_range(0, 4) != 0) write_reg(REG_CLR_FF, 8'($urandom));
    write_reg(addr_sel(ch), 8'($urandom));
    write_reg(addr_sel(ch), 8'($urandom));
    write_reg(count_sel(ch), cnt[7:0]);
    write_reg(count_sel(ch), cnt[15:8]);
    write_reg(REG_MODE, mode_byte);
    write_reg(bank_sel(ch), 8'($urandom));
    rnd = 8'($urandom);
    write_reg(REG_MASK_ONE, {rnd[7:3], 1'b0, ch});
  endtask

  // receiver: random wait per result, plus the long hold-off
  initial begin : receiver
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 79) == 0) quiet_recv = ~quiet_recv;
        wait_left = quiet_recv ? 0 : $urandom_range(0, 16);
      end
      if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else begin
        out_tready <= ~hold_off;
      end
    end
  end

  // long output stall so the block backs up into its input
  initial begin : long_stall
    wait (sent_count >= 700);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #1000000;
    $display("four_channel_dma_controller_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] rnd;
    logic [3:0] expired;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state, ignored and unlisted accesses
    read_reg(REG_COMMAND);
    read_reg(REG_MCLEAR);
    read_reg(REG_MASK_ALL);
    timer_event(4'hf);
    send_item(OP_WRITE, {REG_COMMAND, 8'h76}, 8'h04, 4'h0);
    read_reg(REG_REQUEST);
    send_item(OP_IDLE, 16'hffff, 8'hff, 4'hf);

    // channel 0: autoinit, decrement, address at the top, count of two
    write_reg(REG_CLR_FF, 8'h00);
    write_reg(addr_sel(2'd0), 8'hff);
    write_reg(addr_sel(2'd0), 8'hff);
    write_reg(count_sel(2'd0), 8'h02);
    write_reg(count_sel(2'd0), 8'h00);
    write_reg(REG_MODE, 8'h30);
    write_reg(bank_sel(2'd0), 8'ha5);
    write_reg(REG_MASK_ONE, 8'h00);
    timer_event(4'h1);
    timer_event(4'h1);
    read_reg(REG_COMMAND);

    // disabled controller
    write_reg(REG_COMMAND, 8'h04);
    timer_event(4'hf);
    write_reg(REG_COMMAND, 8'h00);

    // channel 1: block mode, no autoinit, terminal count masks it
    write_reg(count_sel(2'd1), 8'h02);
    write_reg(count_sel(2'd1), 8'h00);
    write_reg(REG_MODE, 8'h81);
    write_reg(REG_CLR_MASK, 8'h00);
    timer_event(4'h2);
    timer_event(4'h0);
    write_reg(REG_MCLEAR, 8'h00);

    // random part: service events, register reads and writes, channel programming and noise
    while (sent_count < RANDOM_ITEMS) begin
      rnd = 8'($urandom);
      case ($urandom_range(0, 99)) inside
        [0:5]: program_channel(rnd[1:0]);
        [6:45]: begin
          expired = ($urandom_range(0, 7) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
          timer_event(expired);
        end
        [46:65]: begin
          case ($urandom_range(0, 5))
            0: read_reg(addr_sel(rnd[1:0]));
            1: read_reg(count_sel(rnd[1:0]));
            2: read_reg(REG_COMMAND);
            3: read_reg(REG_MCLEAR);
            4: read_reg(REG_MASK_ALL);
            default: read_reg(8'($urandom));
          endcase
        end
        [66:91]: begin
          case ($urandom_range(0, 11))
            0: write_reg(REG_COMMAND, ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00);
            1: write_reg(REG_MASK_ONE, 8'($urandom));
            2: write_reg(REG_CLR_MASK, 8'($urandom));
            3: write_reg(REG_MASK_ALL, 8'($urandom));
            4: write_reg(REG_REQUEST, 8'($urandom));
            5: write_reg(REG_MODE, 8'($urandom));
            6: write_reg(bank_sel(rnd[1:0]), 8'($urandom));
            7: write_reg(REG_CLR_FF, 8'($urandom));
            8: write_reg(addr_sel(rnd[1:0]), 8'($urandom));
            9: write_reg(count_sel(rnd[1:0]), 8'($urandom));
            10: write_reg(($urandom_range(0, 9) == 0) ? REG_MCLEAR : REG_CLR_MASK,
                          8'($urandom));
            default: write_reg(8'($urandom), 8'($urandom));
          endcase
        end
        default: begin
          // noise: idle op or a port outside the block
          if (rnd[0]) send_item(OP_IDLE, 16'($urandom), 8'($urandom), 4'($urandom));
          else send_item(op_t'($urandom_range(0, 2)), 16'($urandom), 8'($urandom),
                         4'($urandom));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // drain, then a short margin
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("four_channel_dma_controller_tb passed");
    end else begin
      $display("four_channel_dma_controller_tb failed");
    end
    $finish;
  end

endmodule
